// File: rtl/bpuc_pkg.sv
// Shared types and constants for the BMP pixel unpack and clip block.
// No dependencies; every other file in rtl/ imports this package.
package bpuc_pkg;

    // Default build limits
    localparam int MAX_WIDTH_DEF     = 1024;
    localparam int MAX_HEIGHT_DEF    = 1024;
    localparam int SCREEN_WIDTH_DEF  = 800;
    localparam int SCREEN_HEIGHT_DEF = 480;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int SCR_X_W    = 10;
    localparam int SCR_Y_W    = 9;
    localparam int COLOR_W    = 32;
    localparam int HELD_W     = 24;
    localparam int PHASE_W    = 2;
    localparam int PAD_W      = 2;
    localparam int IMG_DIM_W  = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 3;

    // Result stream payload: x, y, color packed from bit 0, zero-filled to bytes
    localparam int RES_BITS     = SCR_X_W + SCR_Y_W + COLOR_W;
    localparam int OUT_TDATA_W  = ((RES_BITS + 7) / 8) * 8;
    localparam int OUT_FILL_W   = OUT_TDATA_W - RES_BITS;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y     = 3'd4;

    // Pixel sizes in bytes
    localparam logic [2:0] PIX_SIZE_3 = 3'd3;
    localparam logic [2:0] PIX_SIZE_4 = 3'd4;

    typedef struct packed {
        logic [IMG_DIM_W-1:0] image_width;
        logic [IMG_DIM_W-1:0] image_height;
        logic                 four_byte_pixels;
        logic [SCR_X_W-1:0]   offset_x;
        logic [SCR_Y_W-1:0]   offset_y;
    } t_cfg;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [SCR_Y_W-1:0] screen_y;
        logic [SCR_X_W-1:0] screen_x;
    } t_result;

endpackage

// File: rtl/bpuc_cfg.sv
// Configuration register file for the BMP pixel unpack block.
// Depends on bpuc_pkg for register indexes and the t_cfg struct.
module bpuc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [bpuc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpuc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output bpuc_pkg::t_cfg                 o_cfg
);
    import bpuc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width      <= IMG_DIM_W'(1);
            r_cfg.image_height     <= IMG_DIM_W'(1);
            r_cfg.four_byte_pixels <= 1'b0;
            r_cfg.offset_x         <= '0;
            r_cfg.offset_y         <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg.image_width      <= i_cfg_wdata[IMG_DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg.image_height     <= i_cfg_wdata[IMG_DIM_W-1:0];
                CFG_FOUR_BYTE:    r_cfg.four_byte_pixels <= i_cfg_wdata[0];
                CFG_OFFSET_X:     r_cfg.offset_x         <= i_cfg_wdata[SCR_X_W-1:0];
                CFG_OFFSET_Y:     r_cfg.offset_y         <= i_cfg_wdata[SCR_Y_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/bpuc_unpack.sv
// Input register, byte/pixel/row counters and screen clip of the unpack block.
// Depends on bpuc_pkg for t_cfg, t_result and field widths.
module bpuc_unpack #(
    parameter int MAX_WIDTH     = bpuc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = bpuc_pkg::MAX_HEIGHT_DEF,
    parameter int SCREEN_WIDTH  = bpuc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = bpuc_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bpuc_pkg::t_cfg             i_cfg,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [bpuc_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                       i_in_first,
    input  logic                       i_res_ready,
    output logic                       o_res_valid,
    output bpuc_pkg::t_result          o_res
);
    import bpuc_pkg::*;

    localparam int CB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RB = $clog2(MAX_HEIGHT + 1);
    localparam int XW = ((CB > SCR_X_W) ? CB : SCR_X_W) + 1;
    localparam int YW = ((RB > SCR_Y_W) ? RB : SCR_Y_W) + 1;

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_first;

    // Unpack state
    logic [CB-1:0]      r_col, n_col;
    logic [RB-1:0]      r_row, n_row;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [PAD_W-1:0]   r_pad, n_pad;
    logic [HELD_W-1:0]  r_held, n_held;

    logic               advance;
    logic               accept;
    logic [WW-1:0]      w;
    logic [RB-1:0]      h;
    logic [2:0]         pix_size;
    logic [CB-1:0]      col_e;
    logic [RB-1:0]      row_e;
    logic [PHASE_W-1:0] phase_e;
    logic [PAD_W-1:0]   pad_e;
    logic [HELD_W-1:0]  held_e;
    logic [CB:0]        col_inc;
    logic [2:0]         phase_inc;
    logic [XW-1:0]      x;
    logic [YW-1:0]      y;
    logic [COLOR_W-1:0] color;
    logic               emit;

    assign advance    = r_in_valid && i_res_ready;
    assign o_in_ready = !r_in_valid || i_res_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte  <= i_in_byte;
            r_in_first <= i_in_first;
        end
    end

    // Clamp the header dimensions to the build limits
    always_comb begin
        if (32'(i_cfg.image_width) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(i_cfg.image_width);
        end
        if (32'(i_cfg.image_height) > MAX_HEIGHT) begin
            h = RB'(MAX_HEIGHT);
        end else begin
            h = RB'(i_cfg.image_height);
        end
    end

    assign pix_size = i_cfg.four_byte_pixels ? PIX_SIZE_4 : PIX_SIZE_3;

    // First flag restarts the counters before the byte is used
    assign col_e   = r_in_first ? '0 : r_col;
    assign row_e   = r_in_first ? '0 : r_row;
    assign phase_e = r_in_first ? '0 : r_phase;
    assign pad_e   = r_in_first ? '0 : r_pad;
    assign held_e  = r_in_first ? '0 : r_held;

    assign col_inc   = {1'b0, col_e} + (CB+1)'(1);
    assign phase_inc = {1'b0, phase_e} + 3'd1;

    assign x = XW'(i_cfg.offset_x) + XW'(col_e);
    assign y = YW'(i_cfg.offset_y) + YW'(h) - YW'(row_e) - YW'(1);

    always_comb begin
        n_col   = col_e;
        n_row   = row_e;
        n_phase = phase_e;
        n_pad   = pad_e;
        n_held  = held_e;
        emit    = 1'b0;
        color   = {held_e, r_in_byte};
        if (pix_size == PIX_SIZE_3) begin
            color[COLOR_W-1:HELD_W] = '0;
        end
        if (w == '0 || h == '0 || row_e >= h) begin
            // past the last row or empty image: drop the byte
        end else if (pad_e != '0) begin
            n_pad = pad_e - PAD_W'(1);
        end else if (phase_inc < pix_size) begin
            n_held  = {held_e[HELD_W-BYTE_W-1:0], r_in_byte};
            n_phase = phase_inc[PHASE_W-1:0];
        end else begin
            n_held  = '0;
            n_phase = '0;
            emit    = (32'(x) < SCREEN_WIDTH) && (32'(y) < SCREEN_HEIGHT);
            if (32'(col_inc) >= 32'(w)) begin
                n_col = '0;
                n_row = row_e + RB'(1);
                n_pad = i_cfg.four_byte_pixels ? '0 : w[PAD_W-1:0];
            end else begin
                n_col = col_inc[CB-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_phase <= '0;
            r_pad   <= '0;
            r_held  <= '0;
        end else if (advance) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_phase <= n_phase;
            r_pad   <= n_pad;
            r_held  <= n_held;
        end
    end

    assign o_res_valid    = advance && emit;
    assign o_res.screen_x = x[SCR_X_W-1:0];
    assign o_res.screen_y = y[SCR_Y_W-1:0];
    assign o_res.color    = color;

endmodule

// File: rtl/bpuc_out_reg.sv
// Result register driving the master-side stream of the unpack block.
// Depends on bpuc_pkg for t_result and the packed tdata width.
module bpuc_out_reg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_res_valid,
    input  bpuc_pkg::t_result               i_res,
    output logic                            o_res_ready,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [bpuc_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import bpuc_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_res_ready = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {OUT_FILL_W'(0), r_res};

endmodule

// File: rtl/bmp_pixel_unpack_clip_core.sv
// BMP pixel array unpack and clip: one byte in per cycle unless stalled, one screen write per on-screen pixel.
// Each accepted byte passes the input register, then the result register, before its
// screen write request is valid.
// Throughput: one byte per cycle; stalls only while a result waits on the downstream side.
// Reset (synchronous, active low) clears all counters, both valid flags and sets the
// registers to width 1, height 1, 24-bit pixels, zero offsets. No clearing pass.
module bmp_pixel_unpack_clip_core #(
    parameter int MAX_WIDTH     = bpuc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = bpuc_pkg::MAX_HEIGHT_DEF,
    parameter int SCREEN_WIDTH  = bpuc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = bpuc_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [bpuc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bpuc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // byte stream in
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,  // [7:0] pixel_byte
    input  logic                            i_s_tuser,  // [0] first
    // screen write stream out
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [bpuc_pkg::OUT_TDATA_W-1:0] o_m_tdata   // [9:0] screen_x, [18:10] screen_y,
                                                        // [50:19] color, rest zero
);
    import bpuc_pkg::*;

    t_cfg    cfg;
    t_result res;
    logic    res_valid;
    logic    res_ready;

    // Header values; the user writes them only while the stream is idle, the block does not enforce it
    bpuc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Hold the byte, then skip padding, gather pixel bytes, advance
    // column and row, and drop pixels that land off the screen
    bpuc_unpack #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_unpack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_in_byte   (i_s_tdata),
        .i_in_first  (i_s_tuser),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register: the next byte keeps flowing while a result is taken
    bpuc_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // A delivered screen write always lies on the screen
    a_x_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(o_m_tdata[SCR_X_W-1:0]) < SCREEN_WIDTH))
        else $error("screen_x outside screen width");

    a_y_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(o_m_tdata[SCR_X_W+SCR_Y_W-1:SCR_X_W]) < SCREEN_HEIGHT))
        else $error("screen_y outside screen height");

    // An empty result register never blocks the byte stream
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("byte request stalled with empty result register");

    // Reset leaves no result pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule
